FILE: rtl/rgem_pkg.sv
// ----------------------------------------------------------------------------
// rgem_pkg
// Shared types and constants of the raster gray edge marker.
// ----------------------------------------------------------------------------
`default_nettype none

package rgem_pkg;

	localparam int CNT_W   = 27;
	localparam int IMG_W_W = 13;
	localparam int THR_W   = 8;
	localparam int CH_W    = 8;
	localparam int GRAY_W  = 8;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST    = IMG_W_W'(640);
	localparam logic [CNT_W-1:0]   PIXEL_COUNT_RST    = CNT_W'(307200);
	localparam logic [THR_W-1:0]   EDGE_THRESHOLD_RST = THR_W'(30);

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_PIXEL_COUNT    = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic            action;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} px_item_t;

	typedef struct packed {
		logic white;
		logic last;
	} mk_item_t;

	typedef struct packed {
		logic [IMG_W_W-1:0] image_width;
		logic [CNT_W-1:0]   pixel_count;
		logic [THR_W-1:0]   edge_threshold;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic wr_en;
		logic m1_ok;
		logic n1_ok;
		logic mw_ok;
		logic nw_ok;
		logic w_one;
		logic last;
		logic byp0;
		logic byp1;
		logic bypw;
	} emit_req_t;

endpackage

`default_nettype wire

FILE: rtl/rgem_cfg.sv
// ----------------------------------------------------------------------------
// rgem_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgem_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rgem_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rgem_pkg::PDATA_W-1:0] pwdata,
	output logic      [rgem_pkg::PDATA_W-1:0] prdata,
	output rgem_pkg::cfg_t                    cfg
);
	import rgem_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= IMAGE_WIDTH_RST;
			cfg_q.pixel_count    <= PIXEL_COUNT_RST;
			cfg_q.edge_threshold <= EDGE_THRESHOLD_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[IMG_W_W-1:0];
				REG_PIXEL_COUNT:    cfg_q.pixel_count    <= pwdata[CNT_W-1:0];
				REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:    prdata = PDATA_W'(cfg_q.image_width);
			REG_PIXEL_COUNT:    prdata = PDATA_W'(cfg_q.pixel_count);
			REG_EDGE_THRESHOLD: prdata = PDATA_W'(cfg_q.edge_threshold);
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/rgem_ctrl.sv
// ----------------------------------------------------------------------------
// rgem_ctrl
// Input stage: gray conversion, image counters, line buffer pointers and
// the decision which pending pixel is released by each transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rgem_ctrl #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  rgem_pkg::cfg_t                                cfg,
	input  wire logic                                     px_valid,
	output logic                                          px_stall,
	input  rgem_pkg::px_item_t                            px_data,
	input  wire logic                                     s2_free,
	output rgem_pkg::emit_req_t                           req,
	output logic [rgem_pkg::GRAY_W-1:0]                   gray,
	output logic [$clog2(MAX_WIDTH+1)-1:0]                ring_wa,
	output logic [$clog2(MAX_WIDTH+1)-1:0]                ring_ra0,
	output logic [$clog2(MAX_WIDTH+1)-1:0]                ring_ra1,
	output logic [$clog2(MAX_WIDTH+1)-1:0]                ring_raw,
	output logic [$clog2(MAX_WIDTH)-1:0]                  mark_ra,
	output logic [$clog2(MAX_WIDTH)-1:0]                  mark_wa
);
	import rgem_pkg::*;

	localparam int RD  = MAX_WIDTH + 1;
	localparam int RPW = $clog2(RD);
	localparam int MPW = $clog2(MAX_WIDTH);
	localparam int WW  = RPW;
	localparam int TW  = MPW + 1;
	localparam int SUM_W  = CH_W + 2;
	localparam int PROD_W = SUM_W + 10;
	localparam int DIV3_SHIFT = 11;
	localparam logic [PROD_W-1:0] DIV3_MUL = PROD_W'(683);
	localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);

	logic              vld_s1;
	px_item_t          item_s1;

	logic [CNT_W-1:0]  rcv_q;
	logic [CNT_W-1:0]  emt_q;
	logic [CNT_W-1:0]  pend_q;
	logic [RPW-1:0]    rptr_q;
	logic [RPW-1:0]    eptr_q;
	logic [MPW-1:0]    mptr_q;

	logic [WW-1:0]     w;
	logic              px_ok;
	logic              emit;
	logic              adv;
	logic              last;
	logic [CNT_W-1:0]  pend_n;
	logic [CNT_W:0]    e1;
	logic [CNT_W:0]    ew;
	logic [CNT_W:0]    pc_x;
	logic [RPW:0]      sumw;
	logic [TW-1:0]     mdiff;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;

	// gray = sum / 3 through a reciprocal multiply, exact for sums up to 765
	assign sum  = SUM_W'(item_s1.red) + SUM_W'(item_s1.green) + SUM_W'(item_s1.blue);
	assign prod = PROD_W'(sum) * DIV3_MUL;
	assign gray = prod[DIV3_SHIFT +: GRAY_W];

	assign w = (32'(cfg.image_width) > MAX_W32) ? WW'(MAX_WIDTH) : WW'(cfg.image_width);

	assign px_ok  = vld_s1 && !item_s1.action && (rcv_q < cfg.pixel_count);
	assign pend_n = pend_q + CNT_W'(px_ok);
	assign emit   = vld_s1 && (item_s1.action ? (pend_q != '0)
		: (px_ok && (pend_q >= CNT_W'(w))));
	assign adv    = vld_s1 && (!emit || s2_free);
	assign px_stall = vld_s1 && !adv;

	assign e1   = {1'b0, emt_q} + (CNT_W+1)'(1);
	assign ew   = {1'b0, emt_q} + (CNT_W+1)'(w);
	assign pc_x = {1'b0, cfg.pixel_count};
	assign last = e1 >= pc_x;

	assign ring_wa  = rptr_q;
	assign ring_ra0 = eptr_q;
	assign ring_ra1 = (eptr_q == RPW'(RD - 1)) ? '0 : eptr_q + RPW'(1);
	assign sumw     = {1'b0, eptr_q} + (RPW+1)'(w);
	assign ring_raw = (sumw >= (RPW+1)'(RD)) ? RPW'(sumw - (RPW+1)'(RD)) : sumw[RPW-1:0];

	assign mdiff   = {1'b0, mptr_q} + TW'(MAX_WIDTH) - TW'(w);
	assign mark_ra = (mdiff >= TW'(MAX_WIDTH)) ? MPW'(mdiff - TW'(MAX_WIDTH)) : mdiff[MPW-1:0];
	assign mark_wa = mptr_q;

	always_comb begin
		req.emit  = emit;
		req.wr_en = px_ok && adv;
		req.m1_ok = emt_q != '0;
		req.n1_ok = (e1 < pc_x) && (pend_n >= CNT_W'(2));
		req.mw_ok = (w != '0) && (emt_q >= CNT_W'(w));
		req.nw_ok = (w != '0) && (ew < pc_x) && (pend_n > CNT_W'(w));
		req.w_one = w == WW'(1);
		req.last  = last;
		req.byp0  = px_ok && (ring_ra0 == rptr_q);
		req.byp1  = px_ok && (ring_ra1 == rptr_q);
		req.bypw  = px_ok && (ring_raw == rptr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!px_stall) begin
			vld_s1 <= px_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (px_valid && !px_stall) begin
			item_s1 <= px_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q  <= '0;
			emt_q  <= '0;
			pend_q <= '0;
			rptr_q <= '0;
			eptr_q <= '0;
			mptr_q <= '0;
		end else if (adv) begin
			if (emit && last) begin
				rcv_q  <= '0;
				emt_q  <= '0;
				pend_q <= '0;
				rptr_q <= '0;
				eptr_q <= '0;
				mptr_q <= '0;
			end else begin
				if (px_ok) begin
					rcv_q  <= rcv_q + CNT_W'(1);
					rptr_q <= (rptr_q == RPW'(RD - 1)) ? '0 : rptr_q + RPW'(1);
				end
				if (emit) begin
					emt_q  <= emt_q + CNT_W'(1);
					pend_q <= pend_n - CNT_W'(1);
					eptr_q <= ring_ra1;
					mptr_q <= (mptr_q == MPW'(MAX_WIDTH - 1)) ? '0 : mptr_q + MPW'(1);
				end else begin
					pend_q <= pend_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rgem_judge.sv
// ----------------------------------------------------------------------------
// rgem_judge
// Line buffers, neighbor fetch stage, edge decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgem_judge #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [rgem_pkg::THR_W-1:0]       thr,
	input  rgem_pkg::emit_req_t                   req,
	input  wire logic [rgem_pkg::GRAY_W-1:0]      gray,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   ring_wa,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   ring_ra0,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   ring_ra1,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   ring_raw,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]     mark_ra,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]     mark_wa,
	output logic                                  s2_free,
	output logic                                  mk_valid,
	input  wire logic                             mk_stall,
	output rgem_pkg::mk_item_t                    mk_data
);
	import rgem_pkg::*;

	localparam int RD  = MAX_WIDTH + 1;
	localparam int MPW = $clog2(MAX_WIDTH);

	logic [GRAY_W-1:0] ring_a [RD];
	logic [GRAY_W-1:0] ring_b [RD];
	logic [GRAY_W-1:0] ring_c [RD];
	logic [GRAY_W-1:0] mark_mem [MAX_WIDTH];

	logic              vld_s2;
	emit_req_t         flg_s2;
	logic [GRAY_W-1:0] gray_s2;
	logic [GRAY_W-1:0] rd0_s2;
	logic [GRAY_W-1:0] rd1_s2;
	logic [GRAY_W-1:0] rdw_s2;
	logic [GRAY_W-1:0] mrd_s2;
	logic [MPW-1:0]    mptr_s2;

	logic [GRAY_W-1:0] prev_q;
	logic              out_vld_q;
	mk_item_t          out_q;

	logic              out_free;
	logic              ld_s2;
	logic              adv_s2;
	logic [GRAY_W-1:0] g;
	logic [GRAY_W-1:0] n1;
	logic [GRAY_W-1:0] nw;
	logic [GRAY_W-1:0] mw;
	logic              mark;
	logic [GRAY_W-1:0] decided;

	function automatic logic exceeds(input logic [GRAY_W-1:0] c,
		input logic [GRAY_W-1:0] o, input logic [THR_W-1:0] t);
		logic [GRAY_W:0] d;
		d = {1'b0, c} - {1'b0, o};
		return !d[GRAY_W] && (d[GRAY_W-1:0] > t);
	endfunction

	assign out_free = !out_vld_q || !mk_stall;
	assign s2_free  = !vld_s2 || out_free;
	assign ld_s2    = req.emit && s2_free;
	assign adv_s2   = vld_s2 && out_free;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ring_a[ring_wa] <= gray;
		end
		if (ld_s2) begin
			rd0_s2 <= ring_a[ring_ra0];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ring_b[ring_wa] <= gray;
		end
		if (ld_s2) begin
			rd1_s2 <= ring_b[ring_ra1];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ring_c[ring_wa] <= gray;
		end
		if (ld_s2) begin
			rdw_s2 <= ring_c[ring_raw];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mark_mem[mptr_s2] <= decided;
		end
		if (ld_s2) begin
			mrd_s2 <= mark_mem[mark_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			flg_s2  <= req;
			gray_s2 <= gray;
			mptr_s2 <= mark_wa;
		end
		if (adv_s2) begin
			prev_q <= decided;
			out_q  <= '{white: &decided, last: flg_s2.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s2_free) begin
				vld_s2 <= req.emit;
			end
			if (out_free) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	// take the pixel written in the same transfer in place of the stale entry
	assign g  = flg_s2.byp0 ? gray_s2 : rd0_s2;
	assign n1 = flg_s2.byp1 ? gray_s2 : rd1_s2;
	assign nw = flg_s2.bypw ? gray_s2 : rdw_s2;
	assign mw = flg_s2.w_one ? prev_q : mrd_s2;

	assign mark = (flg_s2.m1_ok && exceeds(g, prev_q, thr))
		|| (flg_s2.n1_ok && exceeds(g, n1, thr))
		|| (flg_s2.mw_ok && exceeds(g, mw, thr))
		|| (flg_s2.nw_ok && exceeds(g, nw, thr));
	assign decided = mark ? '1 : g;

	assign mk_valid = out_vld_q;
	assign mk_data  = out_q;

endmodule

`default_nettype wire

FILE: rtl/raster_gray_edge_marker_top.sv
// ----------------------------------------------------------------------------
// raster_gray_edge_marker_top
// Raster gray edge marker: RGB pixels in, one black/white mark per pixel out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock in steady state while neither side stalls.
// Each pixel is turned into gray and judged against its four neighbors; a
// pixel is released once the pixel one row below has arrived, so results
// trail the input by image_width pixels plus three register stages (input,
// neighbor fetch, result). Drain transfers release the pixels still pending
// at the end of an image. The neighbor fetch reads the gray line buffer at
// three places at once, so that buffer is held as three copies of
// MAX_WIDTH+1 entries; a fourth buffer of MAX_WIDTH entries keeps the marks
// of the row above. Line buffers need no clearing after reset.
`default_nettype none

module raster_gray_edge_marker_top #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rgem_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rgem_pkg::PDATA_W-1:0] pwdata,
	output logic      [rgem_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	input  wire logic                         px_valid,
	output logic                              px_stall,
	input  rgem_pkg::px_item_t                px_data,
	output logic                              mk_valid,
	input  wire logic                         mk_stall,
	output rgem_pkg::mk_item_t                mk_data
);
	import rgem_pkg::*;

	localparam int RPW = $clog2(MAX_WIDTH + 1);
	localparam int MPW = $clog2(MAX_WIDTH);

	cfg_t              cfg;
	emit_req_t         req;
	logic              s2_free;
	logic [GRAY_W-1:0] gray;
	logic [RPW-1:0]    ring_wa;
	logic [RPW-1:0]    ring_ra0;
	logic [RPW-1:0]    ring_ra1;
	logic [RPW-1:0]    ring_raw;
	logic [MPW-1:0]    mark_ra;
	logic [MPW-1:0]    mark_wa;

	assign pready = 1'b1;

	rgem_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rgem_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.px_valid (px_valid),
		.px_stall (px_stall),
		.px_data  (px_data),
		.s2_free  (s2_free),
		.req      (req),
		.gray     (gray),
		.ring_wa  (ring_wa),
		.ring_ra0 (ring_ra0),
		.ring_ra1 (ring_ra1),
		.ring_raw (ring_raw),
		.mark_ra  (mark_ra),
		.mark_wa  (mark_wa)
	);

	rgem_judge #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (cfg.edge_threshold),
		.req      (req),
		.gray     (gray),
		.ring_wa  (ring_wa),
		.ring_ra0 (ring_ra0),
		.ring_ra1 (ring_ra1),
		.ring_raw (ring_raw),
		.mark_ra  (mark_ra),
		.mark_wa  (mark_wa),
		.s2_free  (s2_free),
		.mk_valid (mk_valid),
		.mk_stall (mk_stall),
		.mk_data  (mk_data)
	);

	a_stall_only_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		px_stall |-> req.emit)
		else $error("input stalled without a pending release");

	a_below_implies_next: assert property (@(posedge clk) disable iff (!arst_n)
		req.emit && req.nw_ok |-> req.n1_ok)
		else $error("lower neighbor present while right neighbor absent");

	a_above_implies_left: assert property (@(posedge clk) disable iff (!arst_n)
		req.emit && req.mw_ok |-> req.m1_ok)
		else $error("upper neighbor present while left neighbor absent");

	a_last_has_no_next: assert property (@(posedge clk) disable iff (!arst_n)
		req.emit && req.last |-> !req.n1_ok)
		else $error("final pixel of image sees a right neighbor");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the raster gray edge marker.
// ----------------------------------------------------------------------------
// A queue-fed driver sends pixel and drain transfers with random gaps. A
// monitor stalls at random and checks every mark against a local model of the
// gray conversion, neighbor judgment and release order. The run covers reset
// settings, directed corner images, then random images under many register
// settings, including zero and saturated widths and zero and full counts.
`default_nettype none

module testbench;
	import rgem_pkg::*;

	localparam int unsigned MAX_W       = 4096;
	localparam int unsigned RING        = MAX_W + 1;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SETTLE_GAP  = 8;
	localparam int unsigned RAND_ITEMS  = 950;
	localparam logic        ACT_PIXEL   = 1'b0;
	localparam logic        ACT_DRAIN   = 1'b1;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               px_valid = 1'b0;
	logic               px_stall;
	px_item_t           px_data  = '0;
	logic               mk_valid;
	logic               mk_stall = 1'b0;
	mk_item_t           mk_data;

	raster_gray_edge_marker_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.px_valid(px_valid),
		.px_stall(px_stall),
		.px_data (px_data),
		.mk_valid(mk_valid),
		.mk_stall(mk_stall),
		.mk_data (mk_data)
	);

	// Local copy of the block's settings and line state
	logic [IMG_W_W-1:0] cfg_width = IMAGE_WIDTH_RST;
	logic [CNT_W-1:0]   cfg_count = PIXEL_COUNT_RST;
	logic [THR_W-1:0]   cfg_thr   = EDGE_THRESHOLD_RST;
	logic [GRAY_W-1:0]  gray_ring [RING];
	logic [GRAY_W-1:0]  mark_row  [MAX_W];
	logic [CNT_W-1:0]   rcv_count = '0;
	logic [CNT_W-1:0]   emt_count = '0;

	px_item_t    px_pending [$];
	mk_item_t    marks_due  [$];
	mk_item_t    due_mark;
	int unsigned px_gap       = 0;
	int unsigned mk_hold      = 0;
	logic        px_calm      = 1'b0;
	logic        mk_calm      = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches   = 0;
	int unsigned pixels_sent  = 0;
	int unsigned drains_sent  = 0;
	int unsigned marks_seen   = 0;
	int unsigned settings_run = 0;
	int unsigned rand_items   = 0;
	int unsigned tone         = 128;

	function automatic int unsigned eff_width();
		return (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
	endfunction

	function automatic logic exceeds(logic [GRAY_W-1:0] center, logic [GRAY_W-1:0] other);
		return int'(center) - int'(other) > int'(cfg_thr);
	endfunction

	function automatic void judge_oldest();
		int unsigned       e;
		int unsigned       w;
		int unsigned       n;
		logic [GRAY_W-1:0] g;
		logic [GRAY_W-1:0] decided;
		logic              hit;
		mk_item_t          res;
		e   = emt_count;
		w   = eff_width();
		g   = gray_ring[e % RING];
		hit = 1'b0;
		if (e >= 1)
			hit = hit | exceeds(g, mark_row[(e - 1) % MAX_W]);
		n = e + 1;
		if (n < cfg_count && n < rcv_count)
			hit = hit | exceeds(g, gray_ring[n % RING]);
		if (w > 0 && e >= w)
			hit = hit | exceeds(g, mark_row[(e - w) % MAX_W]);
		n = e + w;
		if (w > 0 && n < cfg_count && n < rcv_count)
			hit = hit | exceeds(g, gray_ring[n % RING]);
		decided = hit ? 8'd255 : g;
		mark_row[e % MAX_W] = decided;
		res.white = (decided == 8'd255);
		res.last  = (e + 1 >= cfg_count);
		if (res.last) begin
			rcv_count = '0;
			emt_count = '0;
		end else begin
			emt_count = emt_count + 1'b1;
		end
		marks_due.push_back(res);
	endfunction

	function automatic void absorb_item(px_item_t it);
		logic [9:0] sum;
		if (it.action == ACT_DRAIN) begin
			if (emt_count < rcv_count)
				judge_oldest();
			return;
		end
		if (rcv_count >= cfg_count)
			return;
		sum = it.red + it.green + it.blue;
		gray_ring[rcv_count % RING] = GRAY_W'(sum / 3);
		rcv_count = rcv_count + 1'b1;
		if (emt_count < rcv_count && rcv_count - emt_count > eff_width())
			judge_oldest();
	endfunction

	function automatic int unsigned idle_len(logic calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [CH_W-1:0] near_tone();
		int t;
		t = int'(tone) + int'($urandom_range(0, 24)) - 12;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return CH_W'(t);
	endfunction

	function automatic px_item_t rand_pixel();
		px_item_t it;
		it.action = ACT_PIXEL;
		if ($urandom_range(0, 9) == 0)
			tone = $urandom_range(0, 255);
		case ($urandom_range(0, 3))
			0: begin
				it.red   = $urandom;
				it.green = $urandom;
				it.blue  = $urandom;
			end
			1, 2: begin
				it.red   = near_tone();
				it.green = near_tone();
				it.blue  = near_tone();
			end
			default: begin
				it.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				it.green = it.red;
				it.blue  = it.red;
			end
		endcase
		return it;
	endfunction

	function automatic void push_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		px_item_t it;
		it.action = ACT_PIXEL;
		it.red    = r;
		it.green  = g;
		it.blue   = b;
		px_pending.push_back(it);
		pixels_sent++;
	endfunction

	function automatic void push_rand_pixel();
		px_pending.push_back(rand_pixel());
		pixels_sent++;
	endfunction

	function automatic void push_drain();
		px_item_t it;
		it        = rand_pixel();
		it.action = ACT_DRAIN;
		px_pending.push_back(it);
		drains_sent++;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: transfer pixels from the pending queue, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_valid <= 1'b0;
			px_gap = 0;
		end else begin
			if (px_valid && !px_stall)
				absorb_item(px_data);
			if ($urandom_range(0, 49) == 0)
				px_calm = ~px_calm;
			if (!px_valid || !px_stall) begin
				if (px_gap > 0) begin
					px_gap--;
					px_valid <= 1'b0;
				end else if (px_pending.size() > 0) begin
					px_data  <= px_pending.pop_front();
					px_valid <= 1'b1;
					px_gap = idle_len(px_calm);
				end else begin
					px_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each mark transfer against the oldest one due
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mk_stall <= 1'b0;
			mk_hold = 0;
		end else begin
			if (mk_valid && !mk_stall) begin
				marks_seen++;
				if (marks_due.size() == 0) begin
					$error("mark transfer with no mark due: white %0b last %0b",
						mk_data.white, mk_data.last);
					mismatches++;
				end else begin
					due_mark = marks_due.pop_front();
					if (mk_data.white !== due_mark.white) begin
						$error("white: expected %0b, got %0b", due_mark.white, mk_data.white);
						mismatches++;
					end
					if (mk_data.last !== due_mark.last) begin
						$error("last: expected %0b, got %0b", due_mark.last, mk_data.last);
						mismatches++;
					end
				end
			end
			if ($urandom_range(0, 49) == 0)
				mk_calm = ~mk_calm;
			if (mk_hold > 0) begin
				mk_hold--;
				mk_stall <= 1'b1;
			end else begin
				mk_stall <= 1'b0;
				mk_hold = idle_len(mk_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (px_valid && !px_stall) || (mk_valid && !mk_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("raster_gray_edge_marker_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:    cfg_width = IMG_W_W'(val);
			REG_PIXEL_COUNT:    cfg_count = CNT_W'(val);
			REG_EDGE_THRESHOLD: cfg_thr   = THR_W'(val);
			default: ;
		endcase
	endtask

	task automatic settle();
		while (px_pending.size() != 0 || px_valid || marks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	task automatic set_config(int unsigned wid, int unsigned cnt, int unsigned thr);
		write_reg(REG_IMAGE_WIDTH, wid);
		write_reg(REG_PIXEL_COUNT, cnt);
		write_reg(REG_EDGE_THRESHOLD, thr);
		settings_run++;
	endtask

	// Drain what is pending, then close an open image with a one-pixel tail
	task automatic finish_image();
		settle();
		repeat (int'(rcv_count - emt_count)) push_drain();
		settle();
		if (rcv_count != 0) begin
			write_reg(REG_PIXEL_COUNT, rcv_count + 1);
			push_rand_pixel();
			push_drain();
			settle();
		end
	endtask

	task automatic send_images(int unsigned n_pix, int unsigned n_img);
		int unsigned w_eff;
		int unsigned n_drain;
		w_eff = eff_width();
		repeat (n_img) begin
			for (int i = 0; i < n_pix; i++) begin
				push_rand_pixel();
				if ($urandom_range(0, 15) == 0)
					push_drain();
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) push_rand_pixel();
			n_drain = ((w_eff < n_pix) ? w_eff : n_pix) + $urandom_range(0, 2);
			repeat (n_drain) push_drain();
			rand_items += n_pix + n_drain;
		end
		finish_image();
	endtask

	initial begin
		int unsigned wid;
		int unsigned cnt;
		int unsigned thr;
		int unsigned n_pix;
		int unsigned r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings
		settings_run++;
		repeat (40) push_rand_pixel();
		finish_image();

		// Directed: three-wide rows, extremes of channels, excess pixel, idle drain
		set_config(3, 9, 30);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'hFF, 8'hFE);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'h01, 8'h02, 8'h03);
		push_pixel(8'hFF, 8'h00, 8'h00);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'h00, 8'h00, 8'hFF);
		push_pixel(8'h64, 8'h64, 8'h64);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		repeat (4) push_drain();
		finish_image();
		// Zero width: each pixel released on arrival
		set_config(0, 3, 0);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'h80, 8'h80, 8'h80);
		push_drain();
		finish_image();
		// Zero count: pixels ignored
		set_config(4, 0, 255);
		push_pixel(8'hAA, 8'h55, 8'hAA);
		push_drain();
		finish_image();

		// Extreme settings
		set_config(MAX_W, 24, 255);
		send_images(24, 1);
		set_config(13'h1FFF, 20, 0);
		send_images(20, 2);
		set_config(5, 27'h7FFFFFF, 30);
		send_images(30, 1);
		set_config(1, 7, 30);
		send_images(7, 2);

		while (rand_items < RAND_ITEMS) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				wid = 0;
			else if (r == 1)
				wid = MAX_W;
			else if (r == 2)
				wid = 13'h1FFF;
			else if (r < 9)
				wid = $urandom_range(1, 4);
			else
				wid = $urandom_range(5, 40);
			if (wid == 0 || wid > 64)
				cnt = $urandom_range(1, 40);
			else
				cnt = wid * $urandom_range(1, 5)
					+ (($urandom_range(0, 2) == 0) ? $urandom_range(0, wid - 1) : 0);
			n_pix = cnt;
			if ($urandom_range(0, 24) == 0) begin
				cnt   = 0;
				n_pix = $urandom_range(1, 4);
			end
			r = $urandom_range(0, 7);
			thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 80);
			set_config(wid, cnt, thr);
			send_images(n_pix, $urandom_range(1, 3));
		end

		settle();
		if (marks_due.size() != 0) begin
			$error("%0d marks still due at end of run", marks_due.size());
			mismatches++;
		end
		$display("Sent %0d pixel and %0d drain transfers under %0d register settings.",
			pixels_sent, drains_sent, settings_run);
		$display("Checked %0d mark transfers, %0d mismatches.", marks_seen, mismatches);
		if (mismatches == 0)
			$display("raster_gray_edge_marker_top: match");
		else
			$display("raster_gray_edge_marker_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/rgem_pkg.sv
rtl/rgem_cfg.sv
rtl/rgem_ctrl.sv
rtl/rgem_judge.sv
rtl/raster_gray_edge_marker_top.sv
test/testbench.sv
